[rtl/oacs_pkg.sv]
// ----------------------------------------------------------------------------
// oacs_pkg: shared types and constants of the octahedral atlas cell selector
// Holds the field widths, register indexes, the payload types that pass
// between the pipeline parts, and the small arithmetic helpers.
// ----------------------------------------------------------------------------
package oacs_pkg;

  // Direction components are signed 16-bit values.
  localparam int IN_W      = 16;
  // UV and blend fraction bits.
  localparam int FRAC_BITS = 16;
  // Unsigned UV, one integer bit so that 1.0 can be shown.
  localparam int UV_W      = FRAC_BITS + 1;
  // L1 norm of three 16-bit magnitudes stays below 2^17.
  localparam int L1_W      = IN_W + 1;
  // Divisor 2*L1 and the numerators, which never exceed it.
  localparam int DEN_W     = L1_W + 1;
  // Cell count register width and cell index width.
  localparam int CNT_W     = 9;
  localparam int IDX_W     = 8;
  localparam int MAX_CELLS = 256;
  // u times (count - 1).
  localparam int PROD_W    = UV_W + IDX_W;
  // One quotient bit per divider stage.
  localparam int DIV_STAGES = UV_W;
  // Configuration port index width.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X = 2'd0,
    REG_CELLS_Y = 2'd1
  } oacs_reg_e;

  // Numerators and common divisor of both axes.
  typedef struct packed {
    logic [DEN_W-1:0] num_u;
    logic [DEN_W-1:0] num_v;
    logic [DEN_W-1:0] den;
  } oacs_frac_t;

  // Partial remainders and quotients inside the divider.
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem_u;
    logic [DEN_W-1:0] rem_v;
    logic [UV_W-1:0]  q_u;
    logic [UV_W-1:0]  q_v;
  } oacs_div_t;

  typedef struct packed {
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
  } oacs_uv_t;

  typedef struct packed {
    logic [UV_W-1:0]      enc_u;
    logic [UV_W-1:0]      enc_v;
    logic [IDX_W-1:0]     cell_x0;
    logic [IDX_W-1:0]     cell_y0;
    logic [IDX_W-1:0]     cell_x1;
    logic [IDX_W-1:0]     cell_y1;
    logic [FRAC_BITS-1:0] blend_x;
    logic [FRAC_BITS-1:0] blend_y;
    logic                 valid_res;
  } oacs_res_t;

  // Count above the supported grid size saturates.
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_CELLS);
    sat_count = (n > lim) ? lim : n;
  endfunction

  // One restoring division step on one lane. The first step compares without
  // shifting, since the numerator can equal the divisor.
  function automatic logic [DEN_W:0] div_bit(input logic [DEN_W-1:0] rem,
                                             input logic [DEN_W-1:0] den,
                                             input logic             first);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    logic           ge;
    r2   = first ? {1'b0, rem} : {rem, 1'b0};
    diff = r2 - {1'b0, den};
    ge   = (r2 >= {1'b0, den});
    div_bit = {ge, ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0]};
  endfunction

  function automatic oacs_div_t div_step(input oacs_div_t s, input logic first);
    oacs_div_t     r;
    logic [DEN_W:0] bu;
    logic [DEN_W:0] bv;
    bu      = div_bit(s.rem_u, s.den, first);
    bv      = div_bit(s.rem_v, s.den, first);
    r.den   = s.den;
    r.rem_u = bu[DEN_W-1:0];
    r.rem_v = bv[DEN_W-1:0];
    r.q_u   = {s.q_u[UV_W-2:0], bu[DEN_W]};
    r.q_v   = {s.q_v[UV_W-2:0], bv[DEN_W]};
    div_step = r;
  endfunction

endpackage

[rtl/oacs_front.sv]
// ----------------------------------------------------------------------------
// oacs_front: magnitude, L1 norm and octahedral numerators
// First pipeline stage. Forms the numerators of u and v and the common
// divisor 2*L1, with the hemisphere fold for negative z.
// ----------------------------------------------------------------------------
module oacs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic signed [oacs_pkg::IN_W-1:0] dir_x_i,
  input  logic signed [oacs_pkg::IN_W-1:0] dir_y_i,
  input  logic signed [oacs_pkg::IN_W-1:0] dir_z_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output oacs_pkg::oacs_frac_t            data_o
);

  logic [oacs_pkg::IN_W-1:0]  mag_x;
  logic [oacs_pkg::IN_W-1:0]  mag_y;
  logic [oacs_pkg::IN_W-1:0]  mag_z;
  logic [oacs_pkg::L1_W-1:0]  l1;
  logic [oacs_pkg::DEN_W-1:0] l1_ext;
  logic [oacs_pkg::DEN_W-1:0] den;
  logic                       z_neg;
  oacs_pkg::oacs_frac_t       frac_d;
  oacs_pkg::oacs_frac_t       frac_q;
  logic                       valid_q;

  // The most negative input maps to 32768, which still fits unsigned.
  assign mag_x = dir_x_i[oacs_pkg::IN_W-1] ? (~dir_x_i + 1'b1) : dir_x_i;
  assign mag_y = dir_y_i[oacs_pkg::IN_W-1] ? (~dir_y_i + 1'b1) : dir_y_i;
  assign mag_z = dir_z_i[oacs_pkg::IN_W-1] ? (~dir_z_i + 1'b1) : dir_z_i;
  assign l1    = oacs_pkg::L1_W'(mag_x) + oacs_pkg::L1_W'(mag_y) + oacs_pkg::L1_W'(mag_z);
  assign l1_ext = oacs_pkg::DEN_W'(l1);
  assign den   = {l1, 1'b0};
  assign z_neg = dir_z_i[oacs_pkg::IN_W-1];

  always_comb begin
    frac_d.den = den;
    if (!z_neg) begin
      frac_d.num_u = dir_x_i[oacs_pkg::IN_W-1] ? (l1_ext - oacs_pkg::DEN_W'(mag_x))
                                               : (l1_ext + oacs_pkg::DEN_W'(mag_x));
      frac_d.num_v = dir_y_i[oacs_pkg::IN_W-1] ? (l1_ext - oacs_pkg::DEN_W'(mag_y))
                                               : (l1_ext + oacs_pkg::DEN_W'(mag_y));
    end else begin
      frac_d.num_u = dir_x_i[oacs_pkg::IN_W-1] ? oacs_pkg::DEN_W'(mag_y)
                                               : (den - oacs_pkg::DEN_W'(mag_y));
      frac_d.num_v = dir_y_i[oacs_pkg::IN_W-1] ? oacs_pkg::DEN_W'(mag_x)
                                               : (den - oacs_pkg::DEN_W'(mag_x));
    end
    // A zero vector falls back to forward: 1/2 on both axes.
    if (l1 == '0) begin
      frac_d.num_u = oacs_pkg::DEN_W'(1);
      frac_d.num_v = oacs_pkg::DEN_W'(1);
      frac_d.den   = oacs_pkg::DEN_W'(2);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      frac_q <= frac_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = frac_q;

endmodule

[rtl/oacs_div.sv]
// ----------------------------------------------------------------------------
// oacs_div: pipelined restoring divider for both UV lanes
// Computes floor(num * 2^FRAC_BITS / den) for u and v, one quotient bit per
// stage, with a shared divisor.
// ----------------------------------------------------------------------------
module oacs_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  oacs_pkg::oacs_frac_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output oacs_pkg::oacs_uv_t   data_o
);

  oacs_pkg::oacs_div_t                   init;
  oacs_pkg::oacs_div_t                   stage_q [oacs_pkg::DIV_STAGES];
  logic [oacs_pkg::DIV_STAGES-1:0]       valid_q;
  logic [oacs_pkg::DIV_STAGES-1:0]       stage_rdy;

  assign init.den   = data_i.den;
  assign init.rem_u = data_i.num_u;
  assign init.rem_v = data_i.num_v;
  assign init.q_u   = '0;
  assign init.q_v   = '0;

  for (genvar k = 0; k < oacs_pkg::DIV_STAGES; k++) begin : g_stage
    oacs_pkg::oacs_div_t src;
    oacs_pkg::oacs_div_t stage_d;
    logic                src_v;

    if (k == 0) begin : g_first
      assign src   = init;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = stage_q[k-1];
      assign src_v = valid_q[k-1];
    end

    if (k == oacs_pkg::DIV_STAGES - 1) begin : g_last
      assign stage_rdy[k] = !valid_q[k] || ready_i;
    end else begin : g_mid
      assign stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end

    assign stage_d = oacs_pkg::div_step(src, (k == 0));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_rdy[k]) begin
        valid_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[k] && src_v) begin
        stage_q[k] <= stage_d;
      end
    end
  end

  assign ready_o     = stage_rdy[0];
  assign valid_o     = valid_q[oacs_pkg::DIV_STAGES-1];
  assign data_o.u    = stage_q[oacs_pkg::DIV_STAGES-1].q_u;
  assign data_o.v    = stage_q[oacs_pkg::DIV_STAGES-1].q_v;

endmodule

[rtl/oacs_cell.sv]
// ----------------------------------------------------------------------------
// oacs_cell: atlas cell and blend selection
// Scales UV by (count - 1) in one stage, then splits the product into cell
// index and blend fraction and applies the zero-count rule in the next.
// ----------------------------------------------------------------------------
module oacs_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  oacs_pkg::oacs_uv_t           data_i,
  input  logic [oacs_pkg::CNT_W-1:0]   cells_x_i,
  input  logic [oacs_pkg::CNT_W-1:0]   cells_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output oacs_pkg::oacs_res_t          data_o
);

  typedef struct packed {
    logic [oacs_pkg::UV_W-1:0]   u;
    logic [oacs_pkg::UV_W-1:0]   v;
    logic [oacs_pkg::PROD_W-1:0] prod_x;
    logic [oacs_pkg::PROD_W-1:0] prod_y;
  } scale_t;

  logic [oacs_pkg::CNT_W-1:0]  nsat_x;
  logic [oacs_pkg::CNT_W-1:0]  nsat_y;
  logic [oacs_pkg::CNT_W-1:0]  nm1_x;
  logic [oacs_pkg::CNT_W-1:0]  nm1_y;
  scale_t                      scale_d;
  scale_t                      scale_q;
  logic                        scale_vld_q;
  logic                        scale_rdy;
  oacs_pkg::oacs_res_t         res_d;
  oacs_pkg::oacs_res_t         res_q;
  logic                        res_vld_q;
  logic                        res_rdy;
  logic [oacs_pkg::IDX_W-1:0]  i0_x;
  logic [oacs_pkg::IDX_W-1:0]  i0_y;
  logic [oacs_pkg::CNT_W-1:0]  i1_x;
  logic [oacs_pkg::CNT_W-1:0]  i1_y;

  // The user changes counts only while no request is in flight; unenforced.
  assign nsat_x = oacs_pkg::sat_count(cells_x_i);
  assign nsat_y = oacs_pkg::sat_count(cells_y_i);
  assign nm1_x  = nsat_x - 1'b1;
  assign nm1_y  = nsat_y - 1'b1;

  assign scale_d.u      = data_i.u;
  assign scale_d.v      = data_i.v;
  assign scale_d.prod_x = oacs_pkg::PROD_W'(data_i.u)
                        * oacs_pkg::PROD_W'(nm1_x[oacs_pkg::IDX_W-1:0]);
  assign scale_d.prod_y = oacs_pkg::PROD_W'(data_i.v)
                        * oacs_pkg::PROD_W'(nm1_y[oacs_pkg::IDX_W-1:0]);

  assign res_rdy   = !res_vld_q || ready_i;
  assign scale_rdy = !scale_vld_q || res_rdy;
  assign ready_o   = scale_rdy;

  assign i0_x = scale_q.prod_x[oacs_pkg::FRAC_BITS +: oacs_pkg::IDX_W];
  assign i0_y = scale_q.prod_y[oacs_pkg::FRAC_BITS +: oacs_pkg::IDX_W];
  assign i1_x = oacs_pkg::CNT_W'(i0_x) + 1'b1;
  assign i1_y = oacs_pkg::CNT_W'(i0_y) + 1'b1;

  always_comb begin
    res_d.enc_u     = scale_q.u;
    res_d.enc_v     = scale_q.v;
    res_d.cell_x0   = i0_x;
    res_d.cell_y0   = i0_y;
    res_d.cell_x1   = (i1_x < nsat_x) ? i1_x[oacs_pkg::IDX_W-1:0] : i0_x;
    res_d.cell_y1   = (i1_y < nsat_y) ? i1_y[oacs_pkg::IDX_W-1:0] : i0_y;
    res_d.blend_x   = (nsat_x > oacs_pkg::CNT_W'(1))
                      ? scale_q.prod_x[oacs_pkg::FRAC_BITS-1:0] : '0;
    res_d.blend_y   = (nsat_y > oacs_pkg::CNT_W'(1))
                      ? scale_q.prod_y[oacs_pkg::FRAC_BITS-1:0] : '0;
    res_d.valid_res = 1'b1;
    if (cells_x_i == '0 || cells_y_i == '0) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_vld_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      if (scale_rdy) begin
        scale_vld_q <= valid_i;
      end
      if (res_rdy) begin
        res_vld_q <= scale_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scale_rdy && valid_i) begin
      scale_q <= scale_d;
    end
    if (res_rdy && scale_vld_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_vld_q;
  assign data_o  = res_q;

endmodule

[rtl/octahedral_atlas_cell_select.sv]
// ----------------------------------------------------------------------------
// octahedral_atlas_cell_select: octahedral UV and atlas cell selection
// Maps a direction vector to an octahedral UV and picks the four neighboring
// atlas cells and the two bilinear blend fractions for a configured grid.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   dir_x_i, dir_y_i, dir_z_i
//   out      output     out_valid_o / out_ready_i enc_u_o .. valid_res_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request is accepted per cycle while the output is not stalled, and each
// gives one result after passing the L1 norm and numerator stage, the divider
// stages (one quotient bit per stage) and the cell scaling and selection stages.
// Reset clears all valid bits and sets both cell counts to 8.
// Every stage holds its contents while the stage after it is full and
// stalled, so a stall on the output backs up stage by stage and bubbles fill.
// ----------------------------------------------------------------------------
module octahedral_atlas_cell_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [oacs_pkg::IN_W-1:0]     dir_x_i,
  input  logic signed [oacs_pkg::IN_W-1:0]     dir_y_i,
  input  logic signed [oacs_pkg::IN_W-1:0]     dir_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [oacs_pkg::UV_W-1:0]            enc_u_o,
  output logic [oacs_pkg::UV_W-1:0]            enc_v_o,
  output logic [oacs_pkg::IDX_W-1:0]           cell_x0_o,
  output logic [oacs_pkg::IDX_W-1:0]           cell_y0_o,
  output logic [oacs_pkg::IDX_W-1:0]           cell_x1_o,
  output logic [oacs_pkg::IDX_W-1:0]           cell_y1_o,
  output logic [oacs_pkg::FRAC_BITS-1:0]       blend_x_o,
  output logic [oacs_pkg::FRAC_BITS-1:0]       blend_y_o,
  output logic                                 valid_res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [oacs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [oacs_pkg::CNT_W-1:0]           cfg_data_i
);

  logic [oacs_pkg::CNT_W-1:0] cells_x_q;
  logic [oacs_pkg::CNT_W-1:0] cells_y_q;
  logic                       front_valid;
  logic                       front_ready;
  oacs_pkg::oacs_frac_t       front_data;
  logic                       div_valid;
  logic                       div_ready;
  oacs_pkg::oacs_uv_t         div_data;
  oacs_pkg::oacs_res_t        res;

  // Configuration writes are always taken. An index past the last register
  // is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= oacs_pkg::CNT_W'(8);
      cells_y_q <= oacs_pkg::CNT_W'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        oacs_pkg::REG_CELLS_X: cells_x_q <= cfg_data_i;
        oacs_pkg::REG_CELLS_Y: cells_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Numerators of u and v over the common divisor 2*L1.
  oacs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  // Fixed-point quotients give the UV in UQ1.16.
  oacs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data)
  );

  // The last stage of the cell unit is the output register.
  oacs_cell u_cell (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_valid),
    .ready_o   (div_ready),
    .data_i    (div_data),
    .cells_x_i (cells_x_q),
    .cells_y_i (cells_y_q),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (res)
  );

  assign enc_u_o     = res.enc_u;
  assign enc_v_o     = res.enc_v;
  assign cell_x0_o   = res.cell_x0;
  assign cell_y0_o   = res.cell_y0;
  assign cell_x1_o   = res.cell_x1;
  assign cell_y1_o   = res.cell_y1;
  assign blend_x_o   = res.blend_x;
  assign blend_y_o   = res.blend_y;
  assign valid_res_o = res.valid_res;

  // A result flagged invalid carries zeros in every field.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      enc_u_o == '0 && enc_v_o == '0 && cell_x0_o == '0 && cell_x1_o == '0 &&
      cell_y0_o == '0 && cell_y1_o == '0 && blend_x_o == '0 && blend_y_o == '0)
    else $error("invalid result carries nonzero fields");

  // UV never exceeds 1.0.
  a_uv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> enc_u_o <= oacs_pkg::UV_W'(1 << oacs_pkg::FRAC_BITS) &&
                    enc_v_o <= oacs_pkg::UV_W'(1 << oacs_pkg::FRAC_BITS))
    else $error("encoded UV above one");

  // The upper cell is the lower one or its direct neighbor.
  a_cell_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_x1_o == cell_x0_o || cell_x1_o == cell_x0_o + 1'b1) &&
                    (cell_y1_o == cell_y0_o || cell_y1_o == cell_y0_o + 1'b1))
    else $error("cell pair not adjacent");

  // A single-cell X axis selects cell zero with no blend.
  a_single_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cells_x_q == oacs_pkg::CNT_W'(1) && cells_y_q != '0 |->
      cell_x0_o == '0 && cell_x1_o == '0 && blend_x_o == '0)
    else $error("single cell axis has nonzero index or blend");

endmodule
